### hdl/ddpd_pkg.sv
// Shared types, constants and widths for the differential drive PD controller.
package ddpd_pkg;

  localparam int POS_W  = 24;  // wheel positions and targets
  localparam int HEAD_W = 16;  // bearing input
  localparam int ERR_W  = 25;  // wheel error
  localparam int DERR_W = 26;  // wheel error difference
  localparam int HERR_W = 17;  // bearing error
  localparam int GAIN_W = 16;
  localparam int LIM_W  = 15;
  localparam int PWR_W  = 16;
  localparam int PROD_W = 43;  // one gain product
  localparam int TGT_W  = 44;  // target power before slew limiting

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int FULL_TURN    = 36000;
  localparam int HEADING_TOL  = 100;
  localparam int DISTANCE_TOL = 10;

  // Bearing difference is biased by a whole number of turns so it is never negative.
  localparam int WRAP_TURNS = 235;
  localparam logic [ERR_W-1:0] WRAP_OFFSET = ERR_W'(WRAP_TURNS * FULL_TURN);

  // Reciprocal of a full turn for the quotient estimate; estimate is exact or one low.
  localparam int RECIP_SHIFT = 40;
  localparam int QUOT_W      = 2 * ERR_W - RECIP_SHIFT;
  localparam logic [ERR_W-1:0] RECIP_MUL = ERR_W'((64'd1 << RECIP_SHIFT) / FULL_TURN);

  localparam logic [LIM_W-1:0] LIMIT_RESET = 15'd32512;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_DIST = 2'd1,
    MODE_CW   = 2'd2,
    MODE_CCW  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_TARGET_A   = 3'd1,
    REG_TARGET_B   = 3'd2,
    REG_GAIN_P     = 3'd3,
    REG_GAIN_D     = 3'd4,
    REG_GAIN_KICK  = 3'd5,
    REG_RAMP_LIMIT = 3'd6,
    REG_SPEED_LIM  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    mode_t                   mode;
    logic signed [POS_W-1:0] target_left_or_bearing;
    logic signed [POS_W-1:0] target_right;
    logic [GAIN_W-1:0]       gain_p;
    logic [GAIN_W-1:0]       gain_d;
    logic [LIM_W-1:0]        gain_kick;
    logic [LIM_W-1:0]        ramp_limit;
    logic [LIM_W-1:0]        speed_limit;
  } cfg_t;

  // Errors ready for the gain multipliers. In turn mode the right side carries
  // the negated bearing error.
  typedef struct packed {
    logic                     turn;
    logic signed [ERR_W-1:0]  el;
    logic signed [ERR_W-1:0]  er;
    logic signed [DERR_W-1:0] dl;
    logic signed [DERR_W-1:0] dr;
  } err_t;

  typedef struct packed {
    logic signed [TGT_W-1:0] tl;
    logic signed [TGT_W-1:0] tr;
  } tgt_t;

endpackage

### hdl/ddpd_err.sv
// Input register, bearing wrap and error/derivative formation with error history.
module ddpd_err
  import ddpd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     calibrating,
  input  logic signed [POS_W-1:0]  pos_left,
  input  logic signed [POS_W-1:0]  pos_right,
  input  logic [HEAD_W-1:0]        heading,
  output logic                     out_valid,
  input  logic                     out_ready,
  output err_t                     out_err
);

  localparam logic [ERR_W-1:0]         FULL_TURN_U = ERR_W'(FULL_TURN);
  localparam logic [HERR_W-1:0]        TURN_U      = HERR_W'(FULL_TURN);
  localparam logic signed [HERR_W-1:0] TURN_S      = HERR_W'(FULL_TURN);

  // stage A: input register
  logic                    v_a, turn_a, ccw_a;
  logic signed [POS_W-1:0] pos_l_a, pos_r_a;
  logic [ERR_W-1:0]        u_a;
  logic [ERR_W-1:0]        u_next;

  // stage B: wheel errors and quotient estimate
  logic                    v_b, turn_b, ccw_b;
  logic signed [ERR_W-1:0] el_b, er_b;
  logic [ERR_W-1:0]        u_b;
  logic [QUOT_W-1:0]       q_b;
  logic [2*ERR_W-1:0]      prod;

  // stage C: wrapped bearing error and derivatives
  logic                    v_c;
  err_t                    err_c, err_next;
  logic [ERR_W-1:0]        qm, r0;
  logic [HERR_W-1:0]       r1;
  logic signed [HERR_W-1:0] e_h;
  logic signed [HERR_W:0]  d_h;
  logic signed [HERR_W-1:0] last_err_heading;
  logic signed [ERR_W-1:0]  last_err_left, last_err_right;

  logic en_a, en_b, en_c;

  assign en_c     = !v_c || out_ready;
  assign en_b     = !v_b || en_c;
  assign en_a     = !v_a || en_b;
  assign in_ready = en_a;

  // target bearing minus heading, biased positive
  assign u_next = ERR_W'(cfg.target_left_or_bearing) + (WRAP_OFFSET - ERR_W'(heading));

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (en_a) begin
      v_a <= in_valid && !calibrating && (cfg.mode != MODE_OFF);
    end
    if (en_a) begin
      turn_a  <= (cfg.mode == MODE_CW) || (cfg.mode == MODE_CCW);
      ccw_a   <= (cfg.mode == MODE_CCW);
      pos_l_a <= pos_left;
      pos_r_a <= pos_right;
      u_a     <= u_next;
    end
  end

  assign prod = u_a * RECIP_MUL;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else if (en_b) begin
      v_b <= v_a;
    end
    if (en_b) begin
      turn_b <= turn_a;
      ccw_b  <= ccw_a;
      el_b   <= ERR_W'(cfg.target_left_or_bearing) - ERR_W'(pos_l_a);
      er_b   <= ERR_W'(cfg.target_right) - ERR_W'(pos_r_a);
      u_b    <= u_a;
      q_b    <= prod[2*ERR_W-1:RECIP_SHIFT];
    end
  end

  // remainder is below two turns, one correction step
  assign qm  = ERR_W'(q_b) * FULL_TURN_U;
  assign r0  = u_b - qm;
  assign r1  = (r0[HERR_W-1:0] >= TURN_U) ? r0[HERR_W-1:0] - TURN_U : r0[HERR_W-1:0];
  assign e_h = ccw_b ? $signed(r1) - TURN_S : $signed(r1);
  assign d_h = (HERR_W+1)'(e_h) - (HERR_W+1)'(last_err_heading);

  always_comb begin
    err_next.turn = turn_b;
    if (turn_b) begin
      err_next.el = ERR_W'(e_h);
      err_next.er = -ERR_W'(e_h);
      err_next.dl = DERR_W'(d_h);
      err_next.dr = -DERR_W'(d_h);
    end else begin
      err_next.el = el_b;
      err_next.er = er_b;
      err_next.dl = DERR_W'(el_b) - DERR_W'(last_err_left);
      err_next.dr = DERR_W'(er_b) - DERR_W'(last_err_right);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c              <= 1'b0;
      last_err_heading <= '0;
      last_err_left    <= '0;
      last_err_right   <= '0;
    end else if (en_c) begin
      v_c <= v_b;
      if (v_b) begin
        if (turn_b) begin
          last_err_heading <= e_h;
        end else begin
          last_err_left  <= el_b;
          last_err_right <= er_b;
        end
      end
    end
    if (en_c) begin
      err_c <= err_next;
    end
  end

  assign out_valid = v_c;
  assign out_err   = err_c;

endmodule

### hdl/ddpd_pd.sv
// Gain products, PD sum and near-target kick.
module ddpd_pd
  import ddpd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  err_t in_err,
  output logic out_valid,
  input  logic out_ready,
  output tgt_t out_tgt
);

  localparam logic signed [ERR_W-1:0] HTOL = ERR_W'(HEADING_TOL);
  localparam logic signed [ERR_W-1:0] DTOL = ERR_W'(DISTANCE_TOL);

  logic signed [ERR_W-1:0]  el, er;
  logic signed [DERR_W-1:0] dl, dr;
  logic signed [GAIN_W:0]   gp, gd;
  logic signed [PROD_W-1:0] pl, ql, pr, qr;
  logic                     near_next;

  logic                     v_d, turn_d, near_d;
  logic signed [PROD_W-1:0] pl_d, ql_d, pr_d, qr_d;

  logic signed [TGT_W-1:0]  sl, sr, kick;
  logic                     up_r;
  logic                     v_e;
  tgt_t                     tgt_e;

  logic en_d, en_e;

  assign en_e     = !v_e || out_ready;
  assign en_d     = !v_d || en_e;
  assign in_ready = en_d;

  assign el = in_err.el;
  assign er = in_err.er;
  assign dl = in_err.dl;
  assign dr = in_err.dr;
  assign gp = $signed({1'b0, cfg.gain_p});
  assign gd = $signed({1'b0, cfg.gain_d});

  assign pl = el * gp;
  assign ql = dl * gd;
  assign pr = er * gp;
  assign qr = dr * gd;

  // strict tolerance windows
  assign near_next = in_err.turn ? (el > -HTOL && el < HTOL)
                                 : (el > -DTOL && el < DTOL && er > -DTOL && er < DTOL);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d <= 1'b0;
    end else if (en_d) begin
      v_d <= in_valid;
    end
    if (en_d) begin
      turn_d <= in_err.turn;
      near_d <= near_next;
      pl_d   <= pl;
      ql_d   <= ql;
      pr_d   <= pr;
      qr_d   <= qr;
    end
  end

  assign sl   = TGT_W'(pl_d) + TGT_W'(ql_d);
  assign sr   = TGT_W'(pr_d) + TGT_W'(qr_d);
  assign kick = near_d ? $signed({{(TGT_W-LIM_W){1'b0}}, cfg.gain_kick}) : '0;
  // in turn mode the right target is the negated left one, so a zero gets -kick
  assign up_r = turn_d ? (sr > 0) : (sr >= 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_e <= 1'b0;
    end else if (en_e) begin
      v_e <= v_d;
    end
    if (en_e) begin
      tgt_e.tl <= (sl >= 0) ? sl + kick : sl - kick;
      tgt_e.tr <= up_r ? sr + kick : sr - kick;
    end
  end

  assign out_valid = v_e;
  assign out_tgt   = tgt_e;

endmodule

### hdl/ddpd_slew.sv
// Slew-rate limit, speed clamp and drive power / result register.
module ddpd_slew
  import ddpd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  tgt_t                    in_tgt,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [PWR_W-1:0] power_left,
  output logic signed [PWR_W-1:0] power_right
);

  logic                    v_f;
  logic signed [PWR_W-1:0] drive_left, drive_right;
  logic signed [PWR_W-1:0] left_next, right_next;
  logic                    en_f;

  function automatic logic signed [PWR_W-1:0] slew(
    input logic signed [TGT_W-1:0] tgt,
    input logic signed [PWR_W-1:0] drive,
    input logic [LIM_W-1:0]        ramp,
    input logic [LIM_W-1:0]        speed
  );
    logic signed [TGT_W:0]   diff;
    logic signed [TGT_W:0]   rmp;
    logic signed [PWR_W-1:0] step;
    logic signed [PWR_W:0]   sum;
    logic signed [PWR_W:0]   spd;
    diff = (TGT_W+1)'(tgt) - (TGT_W+1)'(drive);
    rmp  = $signed({{(TGT_W+1-LIM_W){1'b0}}, ramp});
    if (diff > rmp) begin
      step = PWR_W'(rmp);
    end else if (diff < -rmp) begin
      step = PWR_W'(-rmp);
    end else begin
      step = PWR_W'(diff);
    end
    sum = (PWR_W+1)'(drive) + (PWR_W+1)'(step);
    spd = $signed({2'b00, speed});
    if (sum > spd) begin
      slew = PWR_W'(spd);
    end else if (sum < -spd) begin
      slew = PWR_W'(-spd);
    end else begin
      slew = PWR_W'(sum);
    end
  endfunction

  assign en_f     = !v_f || out_ready;
  assign in_ready = en_f;

  assign left_next  = slew(in_tgt.tl, drive_left, cfg.ramp_limit, cfg.speed_limit);
  assign right_next = slew(in_tgt.tr, drive_right, cfg.ramp_limit, cfg.speed_limit);

  // the drive powers double as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      v_f         <= 1'b0;
      drive_left  <= '0;
      drive_right <= '0;
    end else if (en_f) begin
      v_f <= in_valid;
      if (in_valid) begin
        drive_left  <= left_next;
        drive_right <= right_next;
      end
    end
  end

  assign out_valid   = v_f;
  assign power_left  = drive_left;
  assign power_right = drive_right;

endmodule

### hdl/differential_drive_pd_controller_unit.sv
// Top level of the differential drive PD controller: config registers and pipeline.
//
// Sensor ticks arrive on the s_ stream (tdata: pos_left, pos_right, heading;
// tuser: calibrating). Each tick with the mode not off and calibrating low
// gives one request on the m_ stream with the new left and right drive powers.
// Skipped ticks are accepted and dropped without touching any state.
// Registers are written through cfg_we / cfg_index / cfg_data, one per cycle. The user
// must write them only while no tick is in flight; the block does not enforce it.
// From input acceptance to m_tvalid a tick passes the input register,
// wheel errors with the bearing quotient multiply, bearing remainder with
// derivatives, gain products, PD sum with kick, then the slew/clamp register.
// Throughput is one tick per cycle; each stage advances on its own, so
// s_tready stays high while any stage holds a bubble, and drops only once all
// six stages are full behind a stalled m_tready. A stalled result holds.
// Reset (synchronous, rst high) clears the pipeline, error history and drive
// powers, sets mode off and both limits to 32512.
module differential_drive_pd_controller_unit
  import ddpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [63:0]           s_tdata,   // pos_left[23:0], pos_right[47:24], heading[63:48]
  input  logic                  s_tuser,   // calibrating
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // power_left[15:0], power_right[31:16]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  logic err_valid, err_ready, tgt_valid, tgt_ready;
  err_t err;
  tgt_t tgt;
  logic signed [PWR_W-1:0] power_left, power_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode                   <= MODE_OFF;
      cfg.target_left_or_bearing <= '0;
      cfg.target_right           <= '0;
      cfg.gain_p                 <= '0;
      cfg.gain_d                 <= '0;
      cfg.gain_kick              <= '0;
      cfg.ramp_limit             <= LIMIT_RESET;
      cfg.speed_limit            <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:       cfg.mode                   <= mode_t'(cfg_data[1:0]);
        REG_TARGET_A:   cfg.target_left_or_bearing <= $signed(cfg_data[POS_W-1:0]);
        REG_TARGET_B:   cfg.target_right           <= $signed(cfg_data[POS_W-1:0]);
        REG_GAIN_P:     cfg.gain_p                 <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:     cfg.gain_d                 <= cfg_data[GAIN_W-1:0];
        REG_GAIN_KICK:  cfg.gain_kick              <= cfg_data[LIM_W-1:0];
        REG_RAMP_LIMIT: cfg.ramp_limit             <= cfg_data[LIM_W-1:0];
        REG_SPEED_LIM:  cfg.speed_limit            <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  ddpd_err u_err (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .calibrating (s_tuser),
    .pos_left    ($signed(s_tdata[23:0])),
    .pos_right   ($signed(s_tdata[47:24])),
    .heading     (s_tdata[63:48]),
    .out_valid   (err_valid),
    .out_ready   (err_ready),
    .out_err     (err)
  );

  ddpd_pd u_pd (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (err_valid),
    .in_ready  (err_ready),
    .in_err    (err),
    .out_valid (tgt_valid),
    .out_ready (tgt_ready),
    .out_tgt   (tgt)
  );

  ddpd_slew u_slew (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (tgt_valid),
    .in_ready    (tgt_ready),
    .in_tgt      (tgt),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .power_left  (power_left),
    .power_right (power_right)
  );

  assign m_tdata = {power_right, power_left};

`ifndef SYNTHESIS
  // input backs up only when every stage is full behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready && tgt_valid && err_valid))
    else $error("input stalled while the pipeline has room");

  // a new result comes only from a target that was waiting in the PD stage
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(tgt_valid))
    else $error("result appeared without a target");

  // pipeline is empty and ready right after reset
  assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready && !tgt_valid && !err_valid))
    else $error("pipeline not cleared by reset");
`endif

endmodule

### tb/ddpd_power_checker.sv
// Checker for the PD drive unit: mirrors register writes, predicts drive powers, compares.
`timescale 1ns / 100ps
module ddpd_power_checker
  import ddpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [63:0]           s_tdata,   // pos_left[23:0], pos_right[47:24], heading[63:48]
  input  logic                  s_tuser,   // calibrating
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [31:0]           m_tdata,   // power_left[15:0], power_right[31:16]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding,
  output int                    checked
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [PWR_W-1:0] right;
    logic signed [PWR_W-1:0] left;
  } power_pair_t;

  power_pair_t expected_powers[$];

  mode_t  mode_r;
  longint goal_a, goal_b, kp, kd, kick_mag, ramp_lim, speed_cap;
  longint drive_l, drive_r, prev_err_l, prev_err_r, prev_err_h;
  int     err_cnt = 0;
  int     seen = 0;

  function automatic longint sat(input longint x, input longint m);
    if (x > m) return m;
    if (x < -m) return -m;
    return x;
  endfunction

  // zero target power counts as positive
  function automatic longint with_kick(input longint x, input longint k);
    return (x >= 0) ? x + k : x - k;
  endfunction

  function automatic longint magnitude(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  task automatic clear_state();
    mode_r     = MODE_OFF;
    goal_a     = 0;
    goal_b     = 0;
    kp         = 0;
    kd         = 0;
    kick_mag   = 0;
    ramp_lim   = longint'(LIMIT_RESET);
    speed_cap  = longint'(LIMIT_RESET);
    drive_l    = 0;
    drive_r    = 0;
    prev_err_l = 0;
    prev_err_r = 0;
    prev_err_h = 0;
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (reg_idx_t'(idx))
      REG_MODE:       mode_r    = mode_t'(data[1:0]);
      REG_TARGET_A:   goal_a    = longint'($signed(data[POS_W-1:0]));
      REG_TARGET_B:   goal_b    = longint'($signed(data[POS_W-1:0]));
      REG_GAIN_P:     kp        = longint'(data[GAIN_W-1:0]);
      REG_GAIN_D:     kd        = longint'(data[GAIN_W-1:0]);
      REG_GAIN_KICK:  kick_mag  = longint'(data[LIM_W-1:0]);
      REG_RAMP_LIMIT: ramp_lim  = longint'(data[LIM_W-1:0]);
      REG_SPEED_LIM:  speed_cap = longint'(data[LIM_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic predict_tick(input logic [63:0] data, input logic cal);
    longint      el, er, eh, want_l, want_r;
    power_pair_t p;
    if (cal || mode_r == MODE_OFF) return;
    if (mode_r == MODE_CW || mode_r == MODE_CCW) begin
      eh = (goal_a - longint'(data[63:48])) % FULL_TURN;
      if (eh < 0) eh += FULL_TURN;
      if (mode_r == MODE_CCW) eh -= FULL_TURN;
      want_l = eh * kp + (eh - prev_err_h) * kd;
      if (magnitude(eh) < HEADING_TOL) want_l = with_kick(want_l, kick_mag);
      want_r = -want_l;
      prev_err_h = eh;
    end else begin
      el = goal_a - longint'($signed(data[POS_W-1:0]));
      er = goal_b - longint'($signed(data[2*POS_W-1:POS_W]));
      want_l = el * kp + (el - prev_err_l) * kd;
      want_r = er * kp + (er - prev_err_r) * kd;
      prev_err_l = el;
      prev_err_r = er;
      if (magnitude(el) < DISTANCE_TOL && magnitude(er) < DISTANCE_TOL) begin
        want_l = with_kick(want_l, kick_mag);
        want_r = with_kick(want_r, kick_mag);
      end
    end
    // slew toward the target, then cap
    drive_l = sat(drive_l + sat(want_l - drive_l, ramp_lim), speed_cap);
    drive_r = sat(drive_r + sat(want_r - drive_r, ramp_lim), speed_cap);
    p.left  = drive_l[PWR_W-1:0];
    p.right = drive_r[PWR_W-1:0];
    expected_powers.push_back(p);
  endtask

  always @(posedge clk) begin
    power_pair_t got, want;
    if (rst) begin
      clear_state();
      expected_powers.delete();
    end else begin
      // results first, so a tick taken at this edge cannot match them
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        seen++;
        if (expected_powers.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("checker: unexpected request left %0d right %0d", got.left, got.right);
        end else begin
          want = expected_powers.pop_front();
          if (got.left !== want.left || got.right !== want.right) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("checker: request %0d left exp %0d got %0d, right exp %0d got %0d",
                       seen, want.left, got.left, want.right, got.right);
          end
        end
      end
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) predict_tick(s_tdata, s_tuser);
    end
    mismatches  <= err_cnt;
    outstanding <= expected_powers.size();
    checked     <= seen;
  end

endmodule

### tb/differential_drive_pd_controller_unit_tb.sv
// Testbench top for the PD drive unit: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps
module differential_drive_pd_controller_unit_tb;
  import ddpd_pkg::*;

  localparam int ITEM_GOAL     = 1900;
  localparam int PHASE_ITEMS   = 150;
  localparam int OFF_ITEMS     = 20;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 1000000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [63:0]           s_tdata   = '0;  // pos_left[23:0], pos_right[47:24], heading[63:48]
  logic                  s_tuser   = 1'b0;  // calibrating
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [31:0]           m_tdata;   // power_left[15:0], power_right[31:16]
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int mismatches, outstanding, checked;
  int cycle_cnt     = 0;
  int holds_asked   = 0;
  int holds_done    = 0;
  int ticks_sent    = 0;
  int ticks_skipped = 0;
  int settings      = 0;
  bit src_idle      = 1'b0;
  bit snk_idle      = 1'b0;

  // current settings, kept for aiming stimulus near the targets
  mode_t  cur_mode = MODE_OFF;
  longint cur_a    = 0;
  longint cur_b    = 0;

  always #5 clk = ~clk;

  differential_drive_pd_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ddpd_power_checker chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: timeout with %0d results outstanding", outstanding);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint near(input int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic longint any_pos();
    return longint'($signed(POS_W'($urandom)));
  endfunction

  function automatic longint pick_target();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return longint'($urandom_range(0, FULL_TURN - 1));
    if (r < 7) return near(5000);
    return any_pos();
  endfunction

  function automatic longint pick_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return longint'($urandom_range(0, 600));
    if (r < 8) return longint'($urandom_range(0, 4096));
    return longint'($urandom_range(0, 65535));
  endfunction

  // result side: random stalls, plus one long hold on request
  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holds_done != holds_asked) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        stall = snk_idle ? pick_gap() : 0;
        if (stall == 0) begin
          m_tready <= 1'b1;
          @(posedge clk);
        end else begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input longint value, input int width);
    logic [CFG_DATA_W-1:0] mask, junk;
    mask = (CFG_DATA_W'(1) << width) - 1;
    junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : '0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    // bits above the register width must be ignored
    cfg_data  <= (CFG_DATA_W'(value) & mask) | (junk & ~mask);
    @(posedge clk);
  endtask

  task automatic set_all(input mode_t m, input longint a, input longint b, input longint kp,
                         input longint kd, input longint kk, input longint rl, input longint sl);
    write_reg(REG_MODE, longint'(m), 2);
    write_reg(REG_TARGET_A, a, POS_W);
    write_reg(REG_TARGET_B, b, POS_W);
    write_reg(REG_GAIN_P, kp, GAIN_W);
    write_reg(REG_GAIN_D, kd, GAIN_W);
    write_reg(REG_GAIN_KICK, kk, LIM_W);
    write_reg(REG_RAMP_LIMIT, rl, LIM_W);
    write_reg(REG_SPEED_LIM, sl, LIM_W);
    cfg_we   <= 1'b0;
    cur_mode = m;
    cur_a    = a;
    cur_b    = b;
    settings++;
  endtask

  // stop offering and wait until every predicted result is back and the pipe is empty
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_tick(input logic cal, input longint pl, input longint pr,
                           input longint hd);
    int gap;
    gap = src_idle ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cal;
    s_tdata  <= {HEAD_W'(hd), POS_W'(pr), POS_W'(pl)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ticks_sent++;
    if (cal || cur_mode == MODE_OFF) ticks_skipped++;
  endtask

  task automatic random_tick();
    logic   cal;
    longint pl, pr, hd;
    int     sel;
    cal = ($urandom_range(0, 9) == 0);
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      // both wheels close to target so the tolerance window and kick get hit
      pl = cur_a + near(15);
      pr = cur_b + near(15);
    end else begin
      pl = ($urandom_range(0, 1) == 0) ? cur_a + near(3000) : any_pos();
      pr = ($urandom_range(0, 1) == 0) ? cur_b + near(3000) : any_pos();
    end
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      hd = (cur_a + near(150)) % FULL_TURN;
      if (hd < 0) hd += FULL_TURN;
    end else if (sel < 8) begin
      hd = longint'($urandom_range(0, FULL_TURN - 1));
    end else begin
      hd = longint'($urandom_range(0, 65535));
    end
    send_tick(cal, pl, pr, hd);
  endtask

  task automatic random_settings(input mode_t m, input int flavor);
    longint kp, kd, kk, rl, sl;
    kp = pick_gain();
    kd = pick_gain();
    kk = ($urandom_range(0, 1) == 0) ? longint'($urandom_range(0, 1024))
                                     : longint'($urandom_range(0, 32512));
    rl = ($urandom_range(0, 9) < 7) ? longint'($urandom_range(100, 8000))
                                    : longint'($urandom_range(0, 32767));
    sl = ($urandom_range(0, 9) < 7) ? longint'($urandom_range(2000, 32512))
                                    : longint'($urandom_range(0, 32767));
    case (flavor)
      1: begin kp = 65535; kd = 65535; kk = 32512; rl = 0; end
      2: begin kp = 65535; kd = 65535; kk = 32767; rl = 32767; sl = 32767; end
      3: sl = 0;
      4: begin kp = 0; kd = 0; kk = 0; rl = 32512; sl = 32512; end
      default: ;
    endcase
    set_all(m, pick_target(), pick_target(), kp, kd, kk, rl, sl);
  endtask

  initial begin : stimulus
    int    ph, n, len;
    mode_t m;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings leave the mode off: no result
    send_tick(1'b0, 5, -5, 100);
    settle();

    set_all(MODE_DIST, 100, -100, 256, 128, 512, 32512, 32512);
    send_tick(1'b0, 8388607, -8388608, 0);
    send_tick(1'b1, 0, 0, 0);
    send_tick(1'b0, 95, -95, 35999);       // inside tolerance
    send_tick(1'b0, 100, -100, 65535);
    send_tick(1'b0, 100, -100, 0);         // zero target power takes a positive kick
    send_tick(1'b0, 90, -91, 1);           // error of exactly the tolerance
    send_tick(1'b0, -8388608, 8388607, 0);
    settle();

    set_all(MODE_CW, 0, 0, 64, 32, 300, 2000, 30000);
    send_tick(1'b0, 0, 0, 0);
    send_tick(1'b0, 0, 0, 0);
    send_tick(1'b1, 0, 0, 50);
    send_tick(1'b0, 0, 0, 35999);
    send_tick(1'b0, 0, 0, 65535);          // heading beyond a full turn
    send_tick(1'b0, 0, 0, 35950);
    settle();

    set_all(MODE_CCW, -8388608, 0, 64, 32, 300, 32767, 32767);
    send_tick(1'b0, 0, 0, 0);
    send_tick(1'b0, 0, 0, 35999);
    send_tick(1'b0, 0, 0, 65535);
    settle();

    set_all(MODE_CCW, 8388607, 8388607, 64, 32, 300, 32767, 32767);
    send_tick(1'b0, 0, 0, 650);            // just past target going anticlockwise
    send_tick(1'b0, 0, 0, 650);
    settle();

    ph = 0;
    while (ticks_sent < ITEM_GOAL) begin
      settle();
      m = (ph == 5) ? MODE_OFF : mode_t'(ph % 3 + 1);
      random_settings(m, (ph >= 1 && ph <= 4) ? ph : 0);
      src_idle = (ph % 4 != 3);
      snk_idle = (ph % 5 != 2);
      len = (m == MODE_OFF) ? OFF_ITEMS : PHASE_ITEMS;
      for (n = 0; n < len; n++) begin
        if (ph == 3 && n == 30) holds_asked++;     // output stalls while input keeps coming
        if (ph == 6 && n == 75) settle();           // input pauses until all results return
        random_tick();
      end
      ph++;
    end
    settle();

    $display("tb: %0d ticks offered, %0d skipped, %0d drive power requests checked",
             ticks_sent, ticks_skipped, checked);
    $display("tb: %0d register settings over distance and both turn modes, with long stalls",
             settings);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
